/* hdl/tmq_pkg.sv */
// Package for the typed message queue: sizes, status codes, controller states
// and the command and status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
package tmq_pkg;
    localparam int QUEUE_DEPTH  = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int TYPE_W       = 31;
    localparam int OUT_PAY_W    = 32;
    localparam int COUNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W        = $clog2(QUEUE_DEPTH);
    localparam int STATUS_W     = 2;

    localparam logic OP_SEND    = 1'b0;
    localparam logic OP_RECEIVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic take;
    } t_cmd;

    typedef struct packed {
        logic full;
    } t_stat;
endpackage

/* hdl/tmq_if.sv */
// Valid/ready channel interfaces for the typed message queue.
// Depends on tmq_pkg.
`timescale 1ns / 1ps
interface tmq_in_if;
    logic                             valid;
    logic                             ready;
    logic                             operation;
    logic [tmq_pkg::TYPE_W-1:0]       msg_type;
    logic [31:0]                      msg_payload;
    modport source (output valid, operation, msg_type, msg_payload, input ready);
    modport sink   (input valid, operation, msg_type, msg_payload, output ready);
endinterface

interface tmq_out_if;
    logic                             valid;
    logic                             ready;
    logic [tmq_pkg::STATUS_W-1:0]     status;
    logic [tmq_pkg::TYPE_W-1:0]       out_type;
    logic [tmq_pkg::OUT_PAY_W-1:0]    out_payload;
    logic [tmq_pkg::COUNT_W-1:0]      queued_count;
    modport source (output valid, status, out_type, out_payload, queued_count,
                    input ready);
    modport sink   (input valid, status, out_type, out_payload, queued_count,
                    output ready);
endinterface

/* hdl/typed_message_queue_core.sv */
// Top level of the typed message queue: controller, datapath and channel ports.
// Depends on tmq_pkg, tmq_if, tmq_ctrl and tmq_dp.
`timescale 1ns / 1ps
// A bounded queue of typed messages in arrival order. A send appends at the
// tail; a receive removes the oldest message of the requested type from any
// position and closes the gap. A transaction is captured into the input
// registers, then the parallel match and shift over all slots runs in the
// execute state; the result then sits in an output register, and a new
// transaction is taken in the cycle the result is accepted.
module typed_message_queue_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tmq_in_if.sink     i_in,
    tmq_out_if.source  o_out
);
    tmq_pkg::t_cmd w_cmd;

    tmq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd)
    );

    tmq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_operation    (i_in.operation),
        .i_msg_type     (i_in.msg_type),
        .i_msg_payload  (i_in.msg_payload),
        .o_status       (o_out.status),
        .o_out_type     (o_out.out_type),
        .o_out_payload  (o_out.out_payload),
        .o_queued_count (o_out.queued_count)
    );
endmodule

/* hdl/tmq_ctrl.sv */
// Controller for the typed message queue: sequences load, execute and output.
// Depends on tmq_pkg.
`timescale 1ns / 1ps
module tmq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output tmq_pkg::t_cmd   o_cmd
);
    tmq_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tmq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tmq_pkg::S_IDLE: begin
                if (i_in_valid) n_state = tmq_pkg::S_EXEC;
            end
            tmq_pkg::S_EXEC: n_state = tmq_pkg::S_OUT;
            tmq_pkg::S_OUT: begin
                // A new transaction may be taken in the same cycle as the result.
                if (i_out_ready) begin
                    n_state = i_in_valid ? tmq_pkg::S_EXEC : tmq_pkg::S_IDLE;
                end
            end
            default: n_state = tmq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            tmq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            tmq_pkg::S_EXEC: o_cmd.exec = 1'b1;
            tmq_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                o_in_ready  = i_out_ready;
                o_cmd.take  = i_out_ready;
                o_cmd.load  = i_out_ready & i_in_valid;
            end
            default: ;
        endcase
    end
endmodule

/* hdl/tmq_dp.sv */
// Datapath for the typed message queue: slot registers with parallel type
// match, oldest-hit priority select and gap-closing shift. Depends on tmq_pkg.
`timescale 1ns / 1ps
module tmq_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tmq_pkg::t_cmd                      i_cmd,
    input  logic                               i_operation,
    input  logic [tmq_pkg::TYPE_W-1:0]         i_msg_type,
    input  logic [31:0]                        i_msg_payload,
    output logic [tmq_pkg::STATUS_W-1:0]       o_status,
    output logic [tmq_pkg::TYPE_W-1:0]         o_out_type,
    output logic [tmq_pkg::OUT_PAY_W-1:0]      o_out_payload,
    output logic [tmq_pkg::COUNT_W-1:0]        o_queued_count
);
    localparam int D = tmq_pkg::QUEUE_DEPTH;
    localparam int P = tmq_pkg::PAYLOAD_BITS;

    logic [tmq_pkg::TYPE_W-1:0] r_slot_type [D];
    logic [P-1:0]               r_slot_pay  [D];
    logic [tmq_pkg::COUNT_W-1:0] r_count;
    logic                        r_op;
    logic [tmq_pkg::TYPE_W-1:0]  r_type;
    logic [P-1:0]                r_pay;
    logic [tmq_pkg::STATUS_W-1:0]  r_status;
    logic [tmq_pkg::TYPE_W-1:0]    r_out_type;
    logic [tmq_pkg::OUT_PAY_W-1:0] r_out_pay;
    logic [D-1:0]                w_hit;
    logic [D-1:0]                w_first;
    logic [D-1:0]                w_shift;
    logic                        w_found;
    logic [tmq_pkg::TYPE_W-1:0]  w_sel_type;
    logic [P-1:0]                w_sel_pay;
    logic [tmq_pkg::IDX_W-1:0]   w_tail;
    logic [tmq_pkg::OUT_PAY_W+P-1:0] w_pay_wide;
    tmq_pkg::t_stat              w_stat;

    assign w_tail = r_count[tmq_pkg::IDX_W-1:0];
    assign w_stat.full = (r_count == tmq_pkg::COUNT_W'(D));

    always_comb begin
        for (int i = 0; i < D; i++) begin
            w_hit[i] = (r_slot_type[i] == r_type) && (tmq_pkg::COUNT_W'(i) < r_count);
        end
        // Oldest hit, and the mask of slots at or above it that move down.
        w_first = w_hit & (~w_hit + D'(1));
        w_shift = ~(w_first - D'(1));
        w_found = |w_hit;
        w_sel_type = '0;
        w_sel_pay  = '0;
        for (int i = 0; i < D; i++) begin
            if (w_first[i]) begin
                w_sel_type = w_sel_type | r_slot_type[i];
                w_sel_pay  = w_sel_pay | r_slot_pay[i];
            end
        end
    end

    assign w_pay_wide = {{tmq_pkg::OUT_PAY_W{1'b0}}, w_sel_pay};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_operation;
            r_type <= i_msg_type;
            r_pay  <= P'({{P{1'b0}}, i_msg_payload});
        end
        if (i_cmd.exec) begin
            r_out_type <= '0;
            r_out_pay  <= '0;
            r_status   <= tmq_pkg::ST_OK;
            if (r_op == tmq_pkg::OP_SEND) begin
                if (w_stat.full) begin
                    r_status <= tmq_pkg::ST_FULL;
                end else begin
                    r_slot_type[w_tail] <= r_type;
                    r_slot_pay[w_tail]  <= r_pay;
                end
            end else if (!w_found) begin
                r_status <= tmq_pkg::ST_NONE;
            end else begin
                r_out_type <= w_sel_type;
                r_out_pay  <= w_pay_wide[tmq_pkg::OUT_PAY_W-1:0];
                for (int i = 0; i < D - 1; i++) begin
                    if (w_shift[i]) begin
                        r_slot_type[i] <= r_slot_type[i+1];
                        r_slot_pay[i]  <= r_slot_pay[i+1];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            if (r_op == tmq_pkg::OP_SEND) begin
                if (!w_stat.full) r_count <= r_count + 1'b1;
            end else if (w_found) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_status       = r_status;
    assign o_out_type     = r_out_type;
    assign o_out_payload  = r_out_pay;
    assign o_queued_count = r_count;
endmodule

/* dv/tb.sv */
// Self-checking testbench for typed_message_queue_core: directed and random
// send/receive traffic with a behavioural queue predictor and result scoreboard.
// Depends on tmq_pkg, tmq_if and the RTL of the block.
`timescale 1ns / 1ps
module tb;
    typedef struct packed {
        logic [tmq_pkg::STATUS_W-1:0]  status;
        logic [tmq_pkg::TYPE_W-1:0]    mtype;
        logic [tmq_pkg::OUT_PAY_W-1:0] payload;
        logic [tmq_pkg::COUNT_W-1:0]   count;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tmq_in_if  in_ch ();
    tmq_out_if out_ch ();

    typed_message_queue_core uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    // Predictor state.
    logic [tmq_pkg::TYPE_W-1:0]       q_type [tmq_pkg::QUEUE_DEPTH];
    logic [tmq_pkg::PAYLOAD_BITS-1:0] q_pay  [tmq_pkg::QUEUE_DEPTH];
    int                               q_held;

    t_result expected_q[$];
    int      error_count;
    int      result_count;
    int      full_count;
    int      miss_count;
    int      hit_count;
    int      send_idle_pct;
    int      recv_idle_pct;
    longint  cycle_count;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_result predict_queue_op(logic op,
                                                 logic [tmq_pkg::TYPE_W-1:0] mtype,
                                                 logic [31:0] payload);
        t_result r;
        int      hit;
        r = '0;
        r.status = tmq_pkg::ST_OK;
        if (op == tmq_pkg::OP_SEND) begin
            if (q_held >= tmq_pkg::QUEUE_DEPTH) begin
                r.status = tmq_pkg::ST_FULL;
            end else begin
                q_type[q_held] = mtype;
                q_pay[q_held]  = payload[tmq_pkg::PAYLOAD_BITS-1:0];
                q_held++;
            end
        end else begin
            hit = -1;
            for (int i = 0; i < q_held; i++) begin
                if (hit < 0 && q_type[i] == mtype) hit = i;
            end
            if (hit < 0) begin
                r.status = tmq_pkg::ST_NONE;
            end else begin
                r.mtype   = q_type[hit];
                r.payload = tmq_pkg::OUT_PAY_W'(q_pay[hit]);
                for (int i = hit; i + 1 < q_held; i++) begin
                    q_type[i] = q_type[i + 1];
                    q_pay[i]  = q_pay[i + 1];
                end
                q_held--;
            end
        end
        r.count = tmq_pkg::COUNT_W'(q_held);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on result %0d: %s got %0h expected %0h",
                 result_count, what, got, want);
        error_count++;
    endtask

    // Sends one transaction, idling first at random. Valid is left high after
    // the handshake; an idle period in the next call, or wait_drained, takes it down.
    task automatic send_item(logic op, logic [tmq_pkg::TYPE_W-1:0] mtype,
                             logic [31:0] payload);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.operation   <= op;
        in_ch.msg_type    <= mtype;
        in_ch.msg_payload <= payload;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        expected_q.push_back(predict_queue_op(op, mtype, payload));
    endtask

    // Receiver stalls and scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                t_result want;
                if (expected_q.size() == 0) begin
                    $display("unexpected result %0d", result_count);
                    error_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (out_ch.status != want.status)
                        report_mismatch("status", out_ch.status, want.status);
                    if (out_ch.out_type != want.mtype)
                        report_mismatch("type", out_ch.out_type, want.mtype);
                    if (out_ch.out_payload != want.payload)
                        report_mismatch("payload", out_ch.out_payload, want.payload);
                    if (out_ch.queued_count != want.count)
                        report_mismatch("count", out_ch.queued_count, want.count);
                    case (want.status)
                        tmq_pkg::ST_FULL: full_count++;
                        tmq_pkg::ST_NONE: miss_count++;
                        default: hit_count++;
                    endcase
                end
                result_count++;
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > 400000) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_item(tmq_pkg::OP_RECEIVE, '0, '0);             // receive on empty queue
        send_item(tmq_pkg::OP_SEND, '0, '0);
        send_item(tmq_pkg::OP_SEND, {tmq_pkg::TYPE_W{1'b1}}, '1);
        send_item(tmq_pkg::OP_SEND, 31'h5, 32'h1234_5678);
        send_item(tmq_pkg::OP_SEND, 31'h5, 32'h9abc_def0);
        send_item(tmq_pkg::OP_RECEIVE, 31'h5, '1);          // oldest of a duplicated type
        send_item(tmq_pkg::OP_RECEIVE, 31'h7, '0);          // no match in non-empty queue
        send_item(tmq_pkg::OP_RECEIVE, {tmq_pkg::TYPE_W{1'b1}}, '0); // removal from middle
        send_item(tmq_pkg::OP_RECEIVE, '0, '0);             // removal from the head
        send_item(tmq_pkg::OP_RECEIVE, 31'h5, '0);
        for (int i = 0; i < tmq_pkg::QUEUE_DEPTH + 2; i++)  // fill, then send while full
            send_item(tmq_pkg::OP_SEND, 31'(i % 3), $urandom);
        send_item(tmq_pkg::OP_RECEIVE, 31'h2, '0);
        send_item(tmq_pkg::OP_RECEIVE, 31'h1, '0);
    endtask

    task automatic test_random(int count);
        int pool;
        for (int n = 0; n < count; n++) begin
            pool = $urandom_range(3) == 0 ? 0 : 8;
            if ($urandom_range(99) < 55 && q_held < tmq_pkg::QUEUE_DEPTH - 1 || q_held == 0)
                send_item(tmq_pkg::OP_SEND,
                          pool == 0 ? 31'($urandom) : 31'($urandom_range(pool)),
                          $urandom);
            else if ($urandom_range(99) < 10)
                send_item(1'($urandom_range(1)), 31'($urandom), $urandom);
            else if ($urandom_range(99) < 80 && q_held > 0)
                send_item(tmq_pkg::OP_RECEIVE, q_type[$urandom_range(q_held - 1)],
                          $urandom);
            else
                send_item(tmq_pkg::OP_RECEIVE, 31'($urandom_range(pool + 1)), $urandom);
        end
    endtask

    task automatic test_drain();
        while (q_held > 0)
            send_item(tmq_pkg::OP_RECEIVE, q_type[q_held - 1], $urandom);
        wait_drained();
    endtask

    initial begin
        error_count   = 0;
        result_count  = 0;
        full_count    = 0;
        miss_count    = 0;
        hit_count     = 0;
        cycle_count   = 0;
        q_held        = 0;
        send_idle_pct = 31;
        recv_idle_pct = 83;
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.operation   = tmq_pkg::OP_SEND;
        in_ch.msg_type    = '0;
        in_ch.msg_payload = '0;
        out_ch.ready      = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(300);
        wait_drained();             // sender holds off until all results are back
        send_idle_pct = 83;
        recv_idle_pct = 31;
        test_random(600);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(960);
        test_drain();

        $display("Covered %0d transactions: %0d completed, %0d full drops, %0d missed receives.",
                 result_count, hit_count, full_count, miss_count);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
